// ===== sv/slwe_pkg.sv =====
// Package with the character codes, scan phases and number types of the scale line weight extractor.
`timescale 1ns / 1ps

package slwe_pkg;

    localparam logic [7:0] ChrNul     = 8'h00;
    localparam logic [7:0] ChrNewline = 8'h0A;
    localparam logic [7:0] ChrReturn  = 8'h0D;
    localparam logic [7:0] ChrPlus    = 8'h2B;
    localparam logic [7:0] ChrMinus   = 8'h2D;
    localparam logic [7:0] ChrPoint   = 8'h2E;
    localparam logic [7:0] ChrZero    = 8'h30;
    localparam logic [7:0] ChrNine    = 8'h39;
    localparam logic [7:0] ChrE       = 8'h45;

    localparam logic [31:0] MagMax = 32'h7FFF_FFFF;

    localparam int Pow10W = 20;

    typedef enum logic [2:0] {
        PH_SEEK   = 3'd0,
        PH_SIGN   = 3'd1,
        PH_SIGNPT = 3'd2,
        PH_POINT  = 3'd3,
        PH_INT    = 3'd4,
        PH_FRAC   = 3'd5,
        PH_DONE   = 3'd6,
        PH_DEAD   = 3'd7
    } phase_t;

    typedef struct packed {
        logic [31:0] mag;
        logic        ovf;
        logic [2:0]  cnt;
    } num_t;

    function automatic logic [Pow10W-1:0] pow10(input logic [2:0] n);
        logic [Pow10W-1:0] p;
        unique case (n)
            3'd0:    p = 20'd1;
            3'd1:    p = 20'd10;
            3'd2:    p = 20'd100;
            3'd3:    p = 20'd1000;
            3'd4:    p = 20'd10000;
            3'd5:    p = 20'd100000;
            3'd6:    p = 20'd1000000;
            default: p = 20'd1;
        endcase
        return p;
    endfunction

    function automatic num_t push_digit(input num_t a, input logic [3:0] d);
        num_t        r;
        logic [35:0] v;
        r = a;
        v = {1'b0, a.mag, 3'b000} + {3'b000, a.mag, 1'b0} + {32'd0, d};
        if (!a.ovf) begin
            if (v > {4'd0, MagMax}) begin
                r.ovf = 1'b1;
                r.mag = MagMax;
            end
            else begin
                r.mag = v[31:0];
            end
        end
        return r;
    endfunction

endpackage

// ===== sv/scale_line_weight_extractor_core.sv =====
// Top level of the scale line weight extractor: byte scanner, line finish and output stage.
//
//  channel | signals                                   | transfer when
//  --------+-------------------------------------------+----------------------------
//  input   | in_valid, in_ready, rx_byte               | in_valid and in_ready high
//  output  | out_valid, out_ready, weight_scaled, sat. | out_valid and out_ready high
//  config  | cfg_write, cfg_data                       | cfg_write high
//
// A byte is taken when in_valid and in_ready are high; a newline's weight is registered in the result or skid register.
// The rate is one byte per cycle while in_ready is high, as the digit update and finish multiply are combinational.
// A two-entry output stage (result register plus skid register) keeps input flowing
// while one result waits; input stalls only when both entries are full.
// Reset clears the line state, the reset_on_e register and both output entries.
`timescale 1ns / 1ps

module scale_line_weight_extractor_core #(
    parameter int LINE_CAPACITY = 64,
    parameter int FRAC_DIGITS   = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] weight_scaled,
    output logic        saturated
);
    import slwe_pkg::*;

    localparam int              LenW    = $clog2(LINE_CAPACITY);
    localparam logic [LenW-1:0] LenMax  = LenW'(LINE_CAPACITY - 1);
    localparam logic [2:0]      FracLim = 3'(FRAC_DIGITS);
    localparam int              ProdW   = 32 + Pow10W;

    logic            reset_on_e_reg;
    logic [LenW-1:0] len_reg, len_next;
    phase_t          ph_reg, ph_next;
    logic            neg_reg, neg_next;
    num_t            num_reg, num_next;

    logic            out_valid_reg;
    logic [31:0]     out_w_reg;
    logic            out_sat_reg;
    logic            skid_valid_reg;
    logic [31:0]     skid_w_reg;
    logic            skid_sat_reg;

    logic            in_fire;
    logic            res_valid;
    logic [31:0]     res_w;
    logic            res_sat;
    logic            emit;
    logic [2:0]      pad;
    logic [ProdW-1:0] prod;
    logic [31:0]     mag_fin;
    logic            sat_fin;
    logic            out_free;

    function automatic num_t frac_digit(input num_t a, input logic [3:0] d);
        num_t r;
        r = a;
        if (a.cnt < FracLim) begin
            r = push_digit(a, d);
            r.cnt = a.cnt + 3'd1;
        end
        else if (a.cnt == FracLim) begin
            if (d >= 4'd5 && !a.ovf) begin
                if (a.mag >= MagMax) begin
                    r.ovf = 1'b1;
                end
                else begin
                    r.mag = a.mag + 32'd1;
                end
            end
            r.cnt = a.cnt + 3'd1;
        end
        return r;
    endfunction

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;

    // Line finish, worked from the registered state.
    assign emit    = (len_reg != '0)
                  && (ph_reg == PH_INT || ph_reg == PH_FRAC || ph_reg == PH_DONE);
    assign pad     = (num_reg.cnt < FracLim) ? (FracLim - num_reg.cnt) : 3'd0;
    assign prod    = num_reg.mag * pow10(pad);
    assign sat_fin = num_reg.ovf || (prod > ProdW'(MagMax));
    assign mag_fin = sat_fin ? MagMax : prod[31:0];

    always_comb
    begin
        logic       digit;
        logic       point;
        logic       sign;
        logic       start_new;
        logic [7:0] dif;
        logic [3:0] d;

        len_next  = len_reg;
        ph_next   = ph_reg;
        neg_next  = neg_reg;
        num_next  = num_reg;
        res_valid = 1'b0;
        res_w     = neg_reg ? (32'd0 - mag_fin) : mag_fin;
        res_sat   = sat_fin;
        digit     = (rx_byte >= ChrZero) && (rx_byte <= ChrNine);
        point     = (rx_byte == ChrPoint);
        sign      = (rx_byte == ChrPlus) || (rx_byte == ChrMinus);
        dif       = rx_byte - ChrZero;
        d         = digit ? dif[3:0] : 4'd0;
        start_new = 1'b0;

        if (in_fire) begin
            if (reset_on_e_reg && rx_byte == ChrE) begin
                len_next = '0;
                ph_next  = PH_SEEK;
                neg_next = 1'b0;
                num_next = '0;
            end
            if (rx_byte == ChrNewline) begin
                res_valid = emit;
                len_next  = '0;
                ph_next   = PH_SEEK;
                neg_next  = 1'b0;
                num_next  = '0;
            end
            else if (rx_byte != ChrReturn) begin
                if (len_next < LenMax) begin
                    len_next = len_next + LenW'(1);
                    if (ph_next == PH_DONE || ph_next == PH_DEAD) begin
                        ph_next = ph_next;
                    end
                    else if (rx_byte == ChrNul) begin
                        ph_next = (ph_next == PH_INT || ph_next == PH_FRAC) ? PH_DONE : PH_DEAD;
                    end
                    else begin
                        unique case (ph_next)
                            PH_INT:
                            begin
                                if (digit) num_next = push_digit(num_next, d);
                                else if (point) ph_next = PH_FRAC;
                                else ph_next = PH_DONE;
                            end
                            PH_FRAC:
                            begin
                                if (digit) num_next = frac_digit(num_next, d);
                                else ph_next = PH_DONE;
                            end
                            PH_SIGN:
                            begin
                                if (digit) begin
                                    ph_next  = PH_INT;
                                    num_next = push_digit(num_next, d);
                                end
                                else if (point) ph_next = PH_SIGNPT;
                                else start_new = 1'b1;
                            end
                            PH_SIGNPT, PH_POINT:
                            begin
                                if (digit) begin
                                    ph_next  = PH_FRAC;
                                    num_next = frac_digit(num_next, d);
                                end
                                else start_new = 1'b1;
                            end
                            default:
                            begin
                                if (digit) begin
                                    ph_next  = PH_INT;
                                    neg_next = 1'b0;
                                    num_next = push_digit(num_t'('0), d);
                                end
                                else start_new = 1'b1;
                            end
                        endcase
                        if (start_new) begin
                            ph_next  = sign ? PH_SIGN : (point ? PH_POINT : PH_SEEK);
                            neg_next = (rx_byte == ChrMinus);
                            num_next = '0;
                        end
                    end
                end
                else begin
                    len_next = '0;
                    ph_next  = PH_SEEK;
                    neg_next = 1'b0;
                    num_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            reset_on_e_reg <= 1'b0;
            len_reg        <= '0;
            ph_reg         <= PH_SEEK;
            neg_reg        <= 1'b0;
            num_reg        <= '0;
        end
        else begin
            if (cfg_write) reset_on_e_reg <= cfg_data;
            len_reg <= len_next;
            ph_reg  <= ph_next;
            neg_reg <= neg_next;
            num_reg <= num_next;
        end
    end

    // Result register with a skid entry behind it.
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else begin
            if (out_free) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else begin
                    out_valid_reg <= res_valid;
                end
            end
            else if (res_valid) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_w_reg   <= skid_w_reg;
                out_sat_reg <= skid_sat_reg;
            end
            else if (res_valid) begin
                out_w_reg   <= res_w;
                out_sat_reg <= res_sat;
            end
        end
        else if (res_valid) begin
            skid_w_reg   <= res_w;
            skid_sat_reg <= res_sat;
        end
    end

    assign out_valid     = out_valid_reg;
    assign weight_scaled = out_w_reg;
    assign saturated     = out_sat_reg;

    // The skid entry is only ever filled behind a waiting result.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result while the result register is empty");

    // A clamped result is always full scale.
    a_sat_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_sat_reg) |-> (out_w_reg == MagMax || out_w_reg == (32'd0 - MagMax)))
        else $error("saturated result is not at full scale");

    // The most negative code is never produced.
    a_no_min_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_w_reg != 32'h8000_0000))
        else $error("result holds the most negative code");

    // The line length never passes its limit.
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LenMax)
        else $error("line length beyond capacity");

endmodule
